FILE: hw/rtl/mrfct_pkg.sv
package mrfct_pkg;

    // Field widths fixed by the interface.
    localparam int ADC_W  = 10;
    localparam int PCT_W  = 7;
    localparam int TIME_W = 32;
    localparam int MINC_W = 7;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 2;

    // Conversion constants.
    localparam logic [ADC_W-1:0] ADC_FULL  = 10'd1023;
    localparam logic [ADC_W-1:0] PCT_LIMIT = 10'd100;
    localparam logic [PCT_W-1:0] PCT_CLAMP = 7'd99;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_DIVISOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADOPT_WINDOW   = 2'd3;

    // Request to the divider.
    typedef struct packed {
        logic             start;
        logic [ADC_W-1:0] dividend;
        logic [ADC_W-1:0] divisor;
    } div_req_t;

    // Status back from the divider.
    typedef struct packed {
        logic             done;
        logic [ADC_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/mrfct_div.sv
module mrfct_div
    import mrfct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(ADC_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [ADC_W-1:0]  acc_reg,   acc_next;
    logic [ADC_W-1:0]  quo_reg,   quo_next;
    logic [ADC_W-1:0]  dvs_reg,   dvs_next;
    logic [ADC_W:0]    trial;
    logic              fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign trial = {acc_reg, quo_reg[ADC_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                acc_next = ADC_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                acc_next = ADC_W'(trial);
            end
            quo_next = {quo_reg[ADC_W-2:0], fits};
            if (step_reg == STEP_W'(ADC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/moisture_rank_filter_change_tracker_core.sv
// Moisture rank filter and change tracker.
//
// Input channel: in_valid / in_stall with time_ms and adc_sample. One request
// is taken at a time; in_stall is low only while the block is idle.
// Output channel: out_valid / out_stall with one result per input request,
// held in an output register, so the next input request can be taken while a
// result still waits on out_stall.
// Configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
//
// From input request to result register the request passes ST_CHECK and ST_EMIT
// when the measure period has not elapsed; when a sample is stored it also passes
// ST_DIV (the bit-serial divider) and ST_STORE; when the store is full it is also
// ranked in ST_SEL, ST_SEL_TAIL and ST_SEL_DEC before ST_UPDATE. Ranking is a 7-pass
// bitwise search over the sample memory, one read per cycle through its single read
// port, and sets the worst-case rate. The input side reopens in the cycle after the
// result is loaded.
//
// Reset clears the counters, times, percent state and both channels and loads
// the configuration defaults. The sample memory is not cleared; it is always
// filled completely before it is ranked.
module moisture_rank_filter_change_tracker_core
    import mrfct_pkg::*;
#(
    parameter int SAMPLES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    time_ms,
    input  logic [ADC_W-1:0]     adc_sample,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 sample_taken,
    output logic                 changed,
    output logic                 increased,
    output logic [PCT_W-1:0]     moisture_percent,
    output logic [PCT_W-1:0]     max_percent,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW   = $clog2(SAMPLES);
    localparam int LW   = $clog2(SAMPLES + 1);
    localparam int RANK = SAMPLES / 2 + 1;
    localparam int BW   = $clog2(PCT_W);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CHECK    = 9'b000000010,
        ST_DIV      = 9'b000000100,
        ST_STORE    = 9'b000001000,
        ST_SEL      = 9'b000010000,
        ST_SEL_TAIL = 9'b000100000,
        ST_SEL_DEC  = 9'b001000000,
        ST_UPDATE   = 9'b010000000,
        ST_EMIT     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [ADC_W-1:0]  divisor_reg;
    logic [MINC_W-1:0] min_change_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] window_reg;

    // Tracker state.
    logic [AW-1:0]     count_reg,     count_next;
    logic [TIME_W-1:0] last_meas_reg, last_meas_next;
    logic [TIME_W-1:0] last_inc_reg,  last_inc_next;
    logic [PCT_W-1:0]  cur_reg,       cur_next;
    logic [PCT_W-1:0]  peak_reg,      peak_next;

    // Per-request working registers.
    logic [TIME_W-1:0] time_reg,      time_next;
    logic [ADC_W-1:0]  adc_reg,       adc_next;
    logic              taken_reg,     taken_next;
    logic              chg_reg,       chg_next;
    logic              inc_reg,       inc_next;
    logic              win_hit_reg,   win_hit_next;
    logic [PCT_W-1:0]  pct_reg,       pct_next;

    // Rank search registers.
    logic [AW-1:0]     idx_reg,       idx_next;
    logic [LW-1:0]     less_reg,      less_next;
    logic [PCT_W-1:0]  ans_reg,       ans_next;
    logic [BW-1:0]     bit_reg,       bit_next;
    logic              rd_pend_reg,   rd_pend_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              o_taken_reg,   o_chg_reg,   o_inc_reg;
    logic [PCT_W-1:0]  o_cur_reg,     o_peak_reg;
    logic              load_out;

    // Sample memory.
    logic [PCT_W-1:0]  mem [SAMPLES];
    logic [PCT_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic              rd_en;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [TIME_W-1:0] since_meas;
    logic [TIME_W-1:0] since_inc;
    logic [PCT_W-1:0]  trial_val;
    logic [PCT_W-1:0]  diff;
    logic              rise;

    mrfct_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign since_meas = time_reg - last_meas_reg;
    assign since_inc  = time_reg - last_inc_reg;
    assign trial_val  = ans_reg | (PCT_W'(1) << bit_reg);
    assign diff       = (ans_reg > cur_reg) ? (ans_reg - cur_reg) : (cur_reg - ans_reg);
    assign rise       = {1'b0, ans_reg} > ({1'b0, cur_reg} + {1'b0, min_change_reg});

    assign div_req.start    = (state_reg == ST_CHECK) && (since_meas >= period_reg);
    assign div_req.dividend = ADC_FULL - adc_reg;
    assign div_req.divisor  = divisor_reg;

    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_meas_next = last_meas_reg;
        last_inc_next  = last_inc_reg;
        cur_next       = cur_reg;
        peak_next      = peak_reg;
        time_next      = time_reg;
        adc_next       = adc_reg;
        taken_next     = taken_reg;
        chg_next       = chg_reg;
        inc_next       = inc_reg;
        win_hit_next   = win_hit_reg;
        pct_next       = pct_reg;
        idx_next       = idx_reg;
        less_next      = less_reg;
        ans_next       = ans_reg;
        bit_next       = bit_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_pend_next   = 1'b0;

        // Count each returned sample that lies below the trial value.
        if (rd_pend_reg && (rd_data_reg < trial_val))
        begin
            less_next = less_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    time_next  = time_ms;
                    adc_next   = adc_sample;
                    taken_next = 1'b0;
                    chg_next   = 1'b0;
                    inc_next   = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                win_hit_next = since_inc < window_reg;
                if (since_meas >= period_reg)
                begin
                    taken_next     = 1'b1;
                    last_meas_next = time_reg;
                    state_next     = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    // A zero divisor or a quotient beyond the limit reads as the clamp value.
                    if ((divisor_reg == '0) || (div_rsp.quotient > PCT_LIMIT))
                    begin
                        pct_next = PCT_CLAMP;
                    end
                    else
                    begin
                        pct_next = div_rsp.quotient[PCT_W-1:0];
                    end
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                mem_we = 1'b1;
                if (count_reg != AW'(SAMPLES - 1))
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    count_next = '0;
                    ans_next   = '0;
                    bit_next   = BW'(PCT_W - 1);
                    idx_next   = '0;
                    less_next  = '0;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                rd_en        = 1'b1;
                rd_pend_next = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == AW'(SAMPLES - 1))
                begin
                    state_next = ST_SEL_TAIL;
                end
            end
            ST_SEL_TAIL:
            begin
                state_next = ST_SEL_DEC;
            end
            ST_SEL_DEC:
            begin
                // Keep the trial bit while no more than RANK samples lie below it.
                if (less_reg <= LW'(RANK))
                begin
                    ans_next = trial_val;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    idx_next   = '0;
                    less_next  = '0;
                    state_next = ST_SEL;
                end
            end
            ST_UPDATE:
            begin
                if (diff >= min_change_reg)
                begin
                    chg_next = 1'b1;
                    cur_next = ans_reg;
                    if (rise)
                    begin
                        inc_next      = 1'b1;
                        peak_next     = ans_reg;
                        last_inc_next = time_reg;
                    end
                    else if (win_hit_reg)
                    begin
                        peak_next = ans_reg;
                    end
                    else if (ans_reg > peak_reg)
                    begin
                        peak_next = ans_reg;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            last_meas_reg  <= '0;
            last_inc_reg   <= '0;
            cur_reg        <= '0;
            peak_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_meas_reg  <= last_meas_next;
            last_inc_reg   <= last_inc_next;
            cur_reg        <= cur_next;
            peak_reg       <= peak_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg    <= 10'd10;
            min_change_reg <= 7'd5;
            period_reg     <= 32'd1000;
            window_reg     <= 32'd60000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADC_DIVISOR:    divisor_reg    <= cfg_wdata[ADC_W-1:0];
                CFG_MIN_CHANGE:     min_change_reg <= cfg_wdata[MINC_W-1:0];
                CFG_MEASURE_PERIOD: period_reg     <= cfg_wdata[TIME_W-1:0];
                CFG_ADOPT_WINDOW:   window_reg     <= cfg_wdata[TIME_W-1:0];
                default:            divisor_reg    <= divisor_reg;
            endcase
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        adc_reg     <= adc_next;
        taken_reg   <= taken_next;
        chg_reg     <= chg_next;
        inc_reg     <= inc_next;
        win_hit_reg <= win_hit_next;
        pct_reg     <= pct_next;
        idx_reg     <= idx_next;
        less_reg    <= less_next;
        ans_reg     <= ans_next;
        bit_reg     <= bit_next;
        if (load_out)
        begin
            o_taken_reg <= taken_reg;
            o_chg_reg   <= chg_reg;
            o_inc_reg   <= inc_reg;
            o_cur_reg   <= cur_reg;
            o_peak_reg  <= peak_reg;
        end
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg] <= pct_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign sample_taken     = o_taken_reg;
    assign changed          = o_chg_reg;
    assign increased        = o_inc_reg;
    assign moisture_percent = o_cur_reg;
    assign max_percent      = o_peak_reg;

endmodule
